// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the flight phase detector RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check an implication on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// rfpd_pkg
// Types and constants shared by the flight phase detector and its channels.
// ----------------------------------------------------------------------------
package rfpd_pkg;

  localparam int unsigned MEAS_W   = 20;
  localparam int unsigned BUTTON_W = 3;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic        [MEAS_W-1:0]    pressure_t;
  typedef logic signed [MEAS_W-1:0]    meas_t;
  typedef logic        [BUTTON_W-1:0]  button_t;
  typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;

  typedef enum logic [2:0] {
    PH_PRELAUNCH = 3'd0,
    PH_READY     = 3'd1,
    PH_POWERED   = 3'd2,
    PH_COAST     = 3'd3,
    PH_DROGUE    = 3'd4,
    PH_MAIN      = 3'd5,
    PH_END       = 3'd6,
    PH_SDWRITE   = 3'd7
  } phase_t;

  localparam button_t BTN_NONE      = 3'd0;
  localparam button_t BTN_PRELAUNCH = 3'd1;
  localparam button_t BTN_LAUNCH    = 3'd2;
  localparam button_t BTN_END       = 3'd3;
  localparam button_t BTN_WRITE     = 3'd4;

  localparam cfg_idx_t CFG_LAUNCH_ACCEL  = 2'd0;
  localparam cfg_idx_t CFG_BURNOUT_ACCEL = 2'd1;
  localparam cfg_idx_t CFG_MAIN_ALTITUDE = 2'd2;

  typedef struct packed {
    phase_t flight_phase;
    logic   descending;
    logic   button_taken;
  } result_t;

endpackage

// ===== rtl/rfpd_ifs.sv =====
// ----------------------------------------------------------------------------
// rfpd channel interfaces
// Valid/ready channels for samples, results and configuration writes.
// ----------------------------------------------------------------------------
interface rfpd_sample_if;
  logic                valid;
  logic                ready;
  rfpd_pkg::pressure_t pressure_pa;
  rfpd_pkg::meas_t     altitude_dm;
  rfpd_pkg::meas_t     accel_z;
  rfpd_pkg::button_t   button_code;

  modport source (output valid, pressure_pa, altitude_dm, accel_z, button_code,
                  input ready);
  modport sink   (input valid, pressure_pa, altitude_dm, accel_z, button_code,
                  output ready);
endinterface

interface rfpd_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] flight_phase;
  logic       descending;
  logic       button_taken;

  modport source (output valid, flight_phase, descending, button_taken,
                  input ready);
  modport sink   (input valid, flight_phase, descending, button_taken,
                  output ready);
endinterface

interface rfpd_cfg_if;
  logic               valid;
  logic               ready;
  rfpd_pkg::cfg_idx_t index;
  rfpd_pkg::meas_t    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/rocket_flight_phase_detector_top.sv =====
// ----------------------------------------------------------------------------
// rocket_flight_phase_detector_top
// Flags descent against the mean of recent pressures and tracks the flight
// phase from acceleration, altitude, descent and ground buttons.
//
//   channel | dir | payload
//   --------+-----+------------------------------------------------------
//   sample  | in  | pressure_pa, altitude_dm, accel_z, button_code
//   result  | out | flight_phase, descending, button_taken
//   cfg     | in  | index (0 launch, 1 burnout, 2 main altitude), data
//
// One sample per cycle while sample.ready is high; each result is registered,
// via the skid if stalled, after a single pass through the running-total
// compare and phase logic. A two-entry output buffer (result register plus
// skid) absorbs a stalled sample; ready drops only while the skid is full.
// rst (synchronous) returns phase, ring and total to zero; cfg.ready is
// always high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rocket_flight_phase_detector_top #(
  parameter int unsigned RING_DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  rfpd_sample_if.sink          sample,
  rfpd_result_if.source        result,
  rfpd_cfg_if.sink             cfg
);
  import rfpd_pkg::*;

  localparam int unsigned TOTAL_W = MEAS_W + $clog2(RING_DEPTH);
  localparam logic [TOTAL_W-1:0] DEPTH_MUL = TOTAL_W'(RING_DEPTH);

  meas_t launch_accel_threshold;
  meas_t burnout_accel_threshold;
  meas_t main_altitude_threshold;

  phase_t    phase;
  phase_t    phase_next;
  logic      taken;
  logic      desc;
  pressure_t ring [RING_DEPTH];
  logic [TOTAL_W-1:0] ring_total;
  logic [TOTAL_W-1:0] ring_total_next;
  logic [TOTAL_W-1:0] pressure_scaled;

  logic    sample_xfer;
  result_t new_result;
  result_t out_data;
  result_t skid_data;
  logic    out_valid;
  logic    skid_valid;

  assign sample_xfer = sample.valid && sample.ready;
  assign sample.ready = !skid_valid;
  assign cfg.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      launch_accel_threshold  <= '0;
      burnout_accel_threshold <= '0;
      main_altitude_threshold <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_LAUNCH_ACCEL:  launch_accel_threshold  <= cfg.data;
        CFG_BURNOUT_ACCEL: burnout_accel_threshold <= cfg.data;
        CFG_MAIN_ALTITUDE: main_altitude_threshold <= cfg.data;
        default: ;
      endcase
    end
  end

  // Descent: mean below new pressure, i.e. total < pressure * depth
  assign pressure_scaled = TOTAL_W'(sample.pressure_pa) * DEPTH_MUL;
  assign desc = ring_total < pressure_scaled;
  assign ring_total_next = ring_total - TOTAL_W'(ring[RING_DEPTH-1])
                         + TOTAL_W'(sample.pressure_pa);

  // Pressure history: the last tap is the oldest sample
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring[i] <= '0;
      end
      ring_total <= '0;
    end else if (sample_xfer) begin
      ring[0] <= sample.pressure_pa;
      for (int i = 1; i < RING_DEPTH; i++) begin
        ring[i] <= ring[i-1];
      end
      ring_total <= ring_total_next;
    end
  end

  // Phase next state
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_PRELAUNCH: begin
        if (sample.button_code == BTN_PRELAUNCH) phase_next = PH_READY;
        else if (sample.button_code == BTN_END) phase_next = PH_END;
      end
      PH_READY: begin
        if (sample.button_code == BTN_LAUNCH) phase_next = PH_POWERED;
        else if (sample.button_code == BTN_END) phase_next = PH_END;
        else if (sample.accel_z > launch_accel_threshold) phase_next = PH_POWERED;
      end
      PH_POWERED: begin
        if (sample.accel_z < burnout_accel_threshold) phase_next = PH_COAST;
      end
      PH_COAST: begin
        if (desc) phase_next = PH_DROGUE;
      end
      PH_DROGUE: begin
        if (sample.altitude_dm < main_altitude_threshold) phase_next = PH_MAIN;
        else if (sample.button_code == BTN_END) phase_next = PH_END;
      end
      PH_MAIN: begin
        if (!desc) phase_next = PH_END;
        else if (sample.button_code == BTN_END) phase_next = PH_END;
      end
      PH_END: begin
        if (sample.button_code == BTN_PRELAUNCH) phase_next = PH_PRELAUNCH;
        else if (sample.button_code == BTN_WRITE) phase_next = PH_SDWRITE;
      end
      default: phase_next = phase;
    endcase
  end

  // Button consumed: only when the button wins the priority in its phase
  always_comb begin
    taken = 1'b0;
    case (phase)
      PH_PRELAUNCH: taken = (sample.button_code == BTN_PRELAUNCH)
                         || (sample.button_code == BTN_END);
      PH_READY:     taken = (sample.button_code == BTN_LAUNCH)
                         || (sample.button_code == BTN_END);
      PH_DROGUE:    taken = !(sample.altitude_dm < main_altitude_threshold)
                         && (sample.button_code == BTN_END);
      PH_MAIN:      taken = desc && (sample.button_code == BTN_END);
      PH_END:       taken = (sample.button_code == BTN_PRELAUNCH)
                         || (sample.button_code == BTN_WRITE);
      default:      taken = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_PRELAUNCH;
    end else if (sample_xfer) begin
      phase <= phase_next;
    end
  end

  assign new_result = '{flight_phase: phase_next, descending: desc,
                        button_taken: taken};

  // Output register with skid: control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      out_valid  <= skid_valid || sample_xfer;
      skid_valid <= 1'b0;
    end else if (sample_xfer) begin
      skid_valid <= 1'b1;
    end
  end

  // Output register with skid: payload
  always_ff @(posedge clk) begin
    if (!out_valid || result.ready) begin
      out_data <= skid_valid ? skid_data : new_result;
    end else if (sample_xfer) begin
      skid_data <= new_result;
    end
  end

  assign result.valid        = out_valid;
  assign result.flight_phase = out_data.flight_phase;
  assign result.descending   = out_data.descending;
  assign result.button_taken = out_data.button_taken;

  // Skid holds data only behind a pending result
  `ASSERT_CLK(a_skid_behind_out, clk, rst, skid_valid |-> out_valid, "skid without result")
  // Card write phase has no exit
  `ASSERT_CLK(a_sdwrite_sticky, clk, rst, (phase == PH_SDWRITE) |=> (phase == PH_SDWRITE), "left sd write")
  // A consumed button is always a real button code
  `ASSERT_CLK(a_taken_real_button, clk, rst, (sample_xfer && taken) |-> (sample.button_code != BTN_NONE), "taken without button")

endmodule
